### hdl/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types and constants of the CSV field tokenizer: character codes,
// result kinds, front-to-back command format.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int unsigned CntW = 6;
  localparam int unsigned CmdDepth = 4;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;

  localparam logic [2:0] KContent  = 3'd0;
  localparam logic [2:0] KComma    = 3'd1;
  localparam logic [2:0] KNewline  = 3'd2;
  localparam logic [2:0] KText     = 3'd3;
  localparam logic [2:0] KImplicit = 3'd4;
  localparam logic [2:0] KOpenQ    = 3'd5;
  localparam logic [2:0] KStray    = 3'd6;
  localparam logic [2:0] KOverflow = 3'd7;

  typedef enum logic [1:0] {
    OP_EMIT  = 2'd0,
    OP_PAIR  = 2'd1,
    OP_STORE = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [7:0]      ch;
    logic [2:0]      kind;
    logic [CntW-1:0] cnt;
  } cmd_t;

endpackage

### hdl/ctf_front.sv
// ----------------------------------------------------------------------------
// ctf_front
// Input side: classifies each byte, tracks the parse mode and the pending
// run length, and turns each transaction into at most one back-end command.
// ----------------------------------------------------------------------------
module ctf_front #(
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     char_in_i,
  input  logic           end_of_text_i,
  output logic           cmd_vld_o,
  output ctf_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_UNQ    = 4'b0010,
    MODE_QUOTED = 4'b0100,
    MODE_QSEEN  = 4'b1000
  } mode_e;

  mode_e                    mode_q, mode_d;
  logic [ctf_pkg::CntW-1:0] cnt_q, cnt_d;

  logic       is_ctrl, is_fill;
  logic       st_vld;
  logic [7:0] st_ch;
  logic [2:0] st_kind;
  mode_e      st_mode;

  assign is_ctrl = (char_in_i < ctf_pkg::ChSpace) || (char_in_i == ctf_pkg::ChDel);
  assign is_fill = is_ctrl || (char_in_i == ctf_pkg::ChSpace);

  // field start handling
  always_comb begin
    st_vld  = 1'b0;
    st_ch   = 8'h00;
    st_kind = ctf_pkg::KContent;
    st_mode = MODE_START;
    if (char_in_i == ctf_pkg::ChComma) begin
      st_vld  = 1'b1;
      st_kind = ctf_pkg::KComma;
    end else if (char_in_i == ctf_pkg::ChNl) begin
      st_vld  = 1'b1;
      st_kind = ctf_pkg::KNewline;
    end else if (is_fill) begin
      st_vld  = 1'b0;
    end else if (char_in_i == ctf_pkg::ChQuote) begin
      st_mode = MODE_QUOTED;
    end else begin
      st_vld  = 1'b1;
      st_ch   = char_in_i;
      st_mode = MODE_UNQ;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    cmd_vld_o = 1'b0;
    cmd_o     = '0;
    cmd_o.op  = ctf_pkg::OP_EMIT;
    if (accept_i) begin
      if (end_of_text_i) begin
        cmd_vld_o  = 1'b1;
        cmd_o.kind = (mode_q == MODE_QUOTED) ? ctf_pkg::KOpenQ : ctf_pkg::KText;
        mode_d     = MODE_START;
        cnt_d      = '0;
      end else begin
        case (mode_q)
          MODE_UNQ: begin
            if (char_in_i == ctf_pkg::ChComma || char_in_i == ctf_pkg::ChNl) begin
              cmd_vld_o  = 1'b1;
              cmd_o.kind = (char_in_i == ctf_pkg::ChComma) ? ctf_pkg::KComma
                                                           : ctf_pkg::KNewline;
              cnt_d      = '0;
              mode_d     = MODE_START;
            end else if (char_in_i == ctf_pkg::ChQuote) begin
              cmd_vld_o  = 1'b1;
              cmd_o.kind = ctf_pkg::KStray;
              cnt_d      = '0;
              mode_d     = MODE_START;
            end else if (is_fill) begin
              cmd_vld_o = 1'b1;
              if (cnt_q >= ctf_pkg::CntW'(PENDING_DEPTH)) begin
                cmd_o.kind = ctf_pkg::KOverflow;
                cnt_d      = '0;
                mode_d     = MODE_START;
              end else begin
                cmd_o.op  = ctf_pkg::OP_STORE;
                cmd_o.ch  = char_in_i;
                cmd_o.cnt = cnt_q;
                cnt_d     = cnt_q + 1'b1;
              end
            end else begin
              cmd_vld_o  = 1'b1;
              cmd_o.op   = ctf_pkg::OP_FLUSH;
              cmd_o.ch   = char_in_i;
              cmd_o.kind = ctf_pkg::KContent;
              cmd_o.cnt  = cnt_q;
              cnt_d      = '0;
            end
          end
          MODE_QUOTED: begin
            if (char_in_i == ctf_pkg::ChQuote) begin
              mode_d = MODE_QSEEN;
            end else if (!is_ctrl) begin
              cmd_vld_o = 1'b1;
              cmd_o.ch  = char_in_i;
            end
          end
          MODE_QSEEN: begin
            cmd_vld_o = 1'b1;
            if (char_in_i == ctf_pkg::ChQuote) begin
              cmd_o.ch = ctf_pkg::ChQuote;
              mode_d   = MODE_QUOTED;
            end else if (char_in_i == ctf_pkg::ChComma || char_in_i == ctf_pkg::ChNl) begin
              cmd_o.kind = (char_in_i == ctf_pkg::ChComma) ? ctf_pkg::KComma
                                                           : ctf_pkg::KNewline;
              mode_d     = MODE_START;
            end else begin
              // implicit end, then the byte starts a new field
              if (st_vld) begin
                cmd_o.op   = ctf_pkg::OP_PAIR;
                cmd_o.ch   = st_ch;
                cmd_o.kind = st_kind;
              end else begin
                cmd_o.kind = ctf_pkg::KImplicit;
              end
              mode_d = st_mode;
              cnt_d  = '0;
            end
          end
          default: begin
            cmd_vld_o  = st_vld;
            cmd_o.ch   = st_ch;
            cmd_o.kind = st_kind;
            mode_d     = st_mode;
            cnt_d      = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### hdl/ctf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ctf_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module ctf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ctf_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output ctf_pkg::cmd_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(ctf_pkg::CmdDepth);

  ctf_pkg::cmd_t mem_q [ctf_pkg::CmdDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   fill_q;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == (PtrW+1)'(ctf_pkg::CmdDepth));
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### hdl/ctf_back.sv
// ----------------------------------------------------------------------------
// ctf_back
// Back end: holds the pending trailing run in a small memory, carries out
// the queued commands and drives the result register.
// ----------------------------------------------------------------------------
module ctf_back #(
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  ctf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    char_out_o,
  output logic [2:0]    kind_o,
  output logic          last_of_run_o
);

  localparam int unsigned IdxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RD     = 4'b0010,
    ST_EM     = 4'b0100,
    ST_SECOND = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  ctf_pkg::cmd_t            cur_q, cur_d;
  logic [ctf_pkg::CntW-1:0] idx_q, idx_d;
  logic [7:0]               mem_q [PENDING_DEPTH];
  logic [7:0]               rd_q;

  logic       out_vld_q, out_vld_d;
  logic [7:0] out_ch_q, out_ch_d;
  logic [2:0] out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;
  logic       slot_free, load, wr_en;

  assign slot_free     = !out_vld_q || pop;
  assign empty         = !out_vld_q;
  assign char_out_o    = out_ch_q;
  assign kind_o        = out_kind_q;
  assign last_of_run_o = out_last_q;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    wr_en      = 1'b0;
    load       = 1'b0;
    out_ch_d   = out_ch_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            ctf_pkg::OP_STORE: begin
              wr_en     = 1'b1;
              cmd_pop_o = 1'b1;
            end
            ctf_pkg::OP_EMIT: begin
              if (slot_free) begin
                load       = 1'b1;
                out_ch_d   = cmd_i.ch;
                out_kind_d = cmd_i.kind;
                out_last_d = 1'b1;
                cmd_pop_o  = 1'b1;
              end
            end
            ctf_pkg::OP_PAIR: begin
              if (slot_free) begin
                load       = 1'b1;
                out_ch_d   = 8'h00;
                out_kind_d = ctf_pkg::KImplicit;
                out_last_d = 1'b0;
                cmd_pop_o  = 1'b1;
                cur_d      = cmd_i;
                state_d    = ST_SECOND;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
              cur_d     = cmd_i;
              idx_d     = '0;
              state_d   = (cmd_i.cnt == '0) ? ST_SECOND : ST_RD;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_EM;
      end
      ST_EM: begin
        if (slot_free) begin
          load       = 1'b1;
          out_ch_d   = rd_q;
          out_kind_d = ctf_pkg::KContent;
          out_last_d = 1'b0;
          idx_d      = idx_q + 1'b1;
          state_d    = (idx_d == cur_q.cnt) ? ST_SECOND : ST_RD;
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          load       = 1'b1;
          out_ch_d   = cur_q.ch;
          out_kind_d = cur_q.kind;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_vld_d = load || (out_vld_q && !pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cmd_i.cnt[IdxW-1:0]] <= cmd_i.ch;
    end
    rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      out_ch_q   <= out_ch_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

### hdl/csv_field_tokenizer_top.sv
// path: with the queue empty a result passes a queue entry and then the result register;
// a later byte of an unquoted field also passes the back end's ST_SECOND state
// throughput: one byte per cycle while the 4-entry command queue is not full; the back
// end waits on a held result and releases each pending byte via ST_RD and ST_EM
// reset: mode, pending count, queue and result valid flag clear at once; the pending
// memory is not cleared and is only read after it is written
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Streaming CSV field tokenizer: byte input queue port, result queue port.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top #(
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic [2:0] kind_o,
  output logic       last_of_run_o
);

  logic          accept;
  logic          cmd_vld;
  ctf_pkg::cmd_t cmd_w;
  ctf_pkg::cmd_t cmd_r;
  logic          cmd_empty;
  logic          cmd_pop;

  assign accept = push && !full;

  ctf_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd_w)
  );

  ctf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_vld),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_r),
    .empty_o (cmd_empty)
  );

  ctf_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_r),
    .cmd_pop_o     (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .char_out_o    (char_out_o),
    .kind_o        (kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
